/* hw/rtl/hash_ring_successor_lookup_unit_assert.svh */
// Assertion macros used by the hash ring lookup top level.
`ifndef HASH_RING_SUCCESSOR_LOOKUP_UNIT_ASSERT_SVH
`define HASH_RING_SUCCESSOR_LOOKUP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HRSL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hash ring assertion failed");
`define HRSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hash ring assertion failed");
`else
`define HRSL_ASSERT_NOW(lbl, ante, cons)
`define HRSL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/hrsl_pkg.sv */
// Types and constants of the hash ring successor lookup unit.
package hrsl_pkg;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned POINT_W    = 32;
  localparam int unsigned NODE_W     = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);

  function automatic int unsigned tree_fan(int unsigned depth);
    int unsigned f;
    f = 1;
    for (int k = 0; k < 17; k++) begin
      if (f * f < depth) begin
        f = f * 2;
      end
    end
    return f;
  endfunction

  localparam int unsigned TREE_FAN = tree_fan(RING_DEPTH);
  localparam int unsigned NUM_GRP  = (RING_DEPTH + TREE_FAN - 1) / TREE_FAN;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    LU_IDLE,
    LU_CELL,
    LU_GRP,
    LU_FIN,
    LU_PICK,
    LU_DONE
  } lu_state_e;

  typedef struct packed {
    logic ins;
    logic look;
  } ctl_t;

  typedef struct packed {
    logic              hit;
    logic [NODE_W-1:0] owner;
  } hit_t;

  typedef struct packed {
    logic [NODE_W-1:0] owner;
    logic              wrapped;
    status_e           status;
  } res_t;

endpackage

/* hw/rtl/hrsl_cell.sv */
// One ring entry: holds a point and its owner, shifts on insert, flags a successor match.
module hrsl_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hrsl_pkg::ctl_t                ctl_i,
  input  logic                          occ_i,
  input  logic [hrsl_pkg::POINT_W-1:0]  cmp_val_i,
  input  logic [hrsl_pkg::NODE_W-1:0]   new_own_i,
  input  logic [hrsl_pkg::POINT_W-1:0]  left_pt_i,
  input  logic [hrsl_pkg::NODE_W-1:0]   left_own_i,
  input  logic                          left_b_i,
  input  logic                          left_ge_i,
  output logic [hrsl_pkg::POINT_W-1:0]  pt_o,
  output logic [hrsl_pkg::NODE_W-1:0]   own_o,
  output logic                          b_o,
  output logic                          ge_o,
  output hrsl_pkg::hit_t                hit_o
);

  logic [hrsl_pkg::POINT_W-1:0] pt_q, pt_d;
  logic [hrsl_pkg::NODE_W-1:0]  own_q, own_d;
  hrsl_pkg::hit_t               hit_q, hit_d;

  assign b_o   = !occ_i || (pt_q > cmp_val_i);
  assign ge_o  = occ_i && (pt_q >= cmp_val_i);
  assign pt_o  = pt_q;
  assign own_o = own_q;
  assign hit_o = hit_q;

  always_comb begin
    pt_d  = pt_q;
    own_d = own_q;
    hit_d = hit_q;
    if (ctl_i.ins) begin
      if (left_b_i) begin
        pt_d  = left_pt_i;
        own_d = left_own_i;
      end else if (b_o) begin
        pt_d  = cmp_val_i;
        own_d = new_own_i;
      end
    end
    if (ctl_i.look) begin
      hit_d.hit   = ge_o && !left_ge_i;
      hit_d.owner = (ge_o && !left_ge_i) ? own_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q  <= pt_d;
    own_q <= own_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit_d;
    end
  end

endmodule

/* hw/rtl/hrsl_or_reduce.sv */
// Registered OR reduction of one group of match flags and owners.
module hrsl_or_reduce (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  hrsl_pkg::hit_t [hrsl_pkg::TREE_FAN-1:0] in_i,
  output hrsl_pkg::hit_t                          out_o
);

  hrsl_pkg::hit_t acc_d, acc_q;

  always_comb begin
    acc_d = '0;
    for (int k = 0; k < hrsl_pkg::TREE_FAN; k++) begin
      acc_d = acc_d | in_i[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign out_o = acc_q;

endmodule

/* hw/rtl/hash_ring_successor_lookup_unit.sv */
// Top level of the hash ring successor lookup unit.
//
// Keeps up to RING_DEPTH ring points in a sorted row of cells, one point and
// owner per cell. An insert is written into the row in the cycle it is
// accepted: every cell compares the new point against its own and either
// keeps its entry, takes the new one, or takes its left neighbor's, so the
// row stays sorted with equal points placed after the ones already held.
// A lookup compares the key in every cell, registers the one cell that
// holds the first point at or above the key, and collects the owner through
// a two-level registered OR tree. Insert, clear and dropped items go straight
// to the done state; a lookup on a non-empty ring passes the cell, group,
// fin and pick states first. One item is in progress at a time; a finished
// result waits in the output register while the next item is accepted.
`include "hash_ring_successor_lookup_unit_assert.svh"

module hash_ring_successor_lookup_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] ring_point, [39:32] owner_node, [71:40] key_hash
  input  logic [71:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] chosen_node, [8] wrapped, [15:9] zero
  output logic [15:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned DEPTH = hrsl_pkg::RING_DEPTH;
  localparam int unsigned FAN   = hrsl_pkg::TREE_FAN;
  localparam int unsigned NGRP  = hrsl_pkg::NUM_GRP;
  localparam int unsigned PW    = hrsl_pkg::POINT_W;
  localparam int unsigned NW    = hrsl_pkg::NODE_W;
  localparam int unsigned CW    = hrsl_pkg::CNT_W;

  hrsl_pkg::lu_state_e state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [PW-1:0]       key_q, key_d;
  hrsl_pkg::res_t      res_q, res_d;
  hrsl_pkg::res_t      out_q, out_d;
  logic                out_vld_q, out_vld_d;
  hrsl_pkg::ctl_t      ctl;

  logic [PW-1:0]       in_point;
  logic [NW-1:0]       in_owner;
  logic [PW-1:0]       in_key;
  hrsl_pkg::kind_e     in_kind;
  logic                in_acc;
  logic                out_free;
  logic [PW-1:0]       cmp_val;

  logic [PW-1:0]       cell_pt  [DEPTH];
  logic [NW-1:0]       cell_own [DEPTH];
  logic                cell_b   [DEPTH];
  logic                cell_ge  [DEPTH];
  hrsl_pkg::hit_t      cell_hit [DEPTH];

  hrsl_pkg::hit_t [NGRP-1:0]             grp_hit;
  hrsl_pkg::hit_t [NGRP-1:0][FAN-1:0]    grp_in;
  hrsl_pkg::hit_t [FAN-1:0]              top_in;
  hrsl_pkg::hit_t                        top_hit;

  assign in_point = s_axis_tdata[PW-1:0];
  assign in_owner = s_axis_tdata[PW+NW-1:PW];
  assign in_key   = s_axis_tdata[2*PW+NW-1:PW+NW];
  assign in_kind  = hrsl_pkg::kind_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign cmp_val  = (state_q == hrsl_pkg::LU_IDLE) ? in_point : key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          occ;
    logic [PW-1:0] l_pt;
    logic [NW-1:0] l_own;
    logic          l_b;
    logic          l_ge;

    assign occ = count_q > CW'(i);
    if (i == 0) begin : g_first
      assign l_pt  = '0;
      assign l_own = '0;
      assign l_b   = 1'b0;
      assign l_ge  = 1'b0;
    end else begin : g_next
      assign l_pt  = cell_pt[i-1];
      assign l_own = cell_own[i-1];
      assign l_b   = cell_b[i-1];
      assign l_ge  = cell_ge[i-1];
    end

    hrsl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .occ_i      (occ),
      .cmp_val_i  (cmp_val),
      .new_own_i  (in_owner),
      .left_pt_i  (l_pt),
      .left_own_i (l_own),
      .left_b_i   (l_b),
      .left_ge_i  (l_ge),
      .pt_o       (cell_pt[i]),
      .own_o      (cell_own[i]),
      .b_o        (cell_b[i]),
      .ge_o       (cell_ge[i]),
      .hit_o      (cell_hit[i])
    );
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar j = 0; j < FAN; j++) begin : g_leaf
      if (g * FAN + j < DEPTH) begin : g_used
        assign grp_in[g][j] = cell_hit[g*FAN+j];
      end else begin : g_pad
        assign grp_in[g][j] = '0;
      end
    end

    hrsl_or_reduce u_grp (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .in_i   (grp_in[g]),
      .out_o  (grp_hit[g])
    );
  end

  for (genvar j = 0; j < FAN; j++) begin : g_top
    if (j < NGRP) begin : g_used
      assign top_in[j] = grp_hit[j];
    end else begin : g_pad
      assign top_in[j] = '0;
    end
  end

  hrsl_or_reduce u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (top_in),
    .out_o  (top_hit)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hrsl_pkg::LU_IDLE: begin
        if (in_acc) begin
          if (in_kind == hrsl_pkg::KIND_LOOKUP && count_q != '0) begin
            state_d = hrsl_pkg::LU_CELL;
          end else begin
            state_d = hrsl_pkg::LU_DONE;
          end
        end
      end
      hrsl_pkg::LU_CELL: state_d = hrsl_pkg::LU_GRP;
      hrsl_pkg::LU_GRP:  state_d = hrsl_pkg::LU_FIN;
      hrsl_pkg::LU_FIN:  state_d = hrsl_pkg::LU_PICK;
      hrsl_pkg::LU_PICK: state_d = hrsl_pkg::LU_DONE;
      hrsl_pkg::LU_DONE: begin
        if (out_free) begin
          state_d = hrsl_pkg::LU_IDLE;
        end
      end
      default: state_d = hrsl_pkg::LU_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ctl           = '0;
    count_d       = count_q;
    key_d         = key_q;
    res_d         = res_q;
    out_d         = out_q;
    out_vld_d     = out_vld_q && !m_axis_tready;
    unique case (state_q)
      hrsl_pkg::LU_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          res_d = '0;
          unique case (in_kind)
            hrsl_pkg::KIND_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                res_d.status = hrsl_pkg::ST_FULL;
              end else begin
                ctl.ins = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            hrsl_pkg::KIND_LOOKUP: begin
              key_d = in_key;
              if (count_q == '0) begin
                res_d.status = hrsl_pkg::ST_EMPTY;
              end
            end
            hrsl_pkg::KIND_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      hrsl_pkg::LU_CELL: begin
        ctl.look = 1'b1;
      end
      hrsl_pkg::LU_PICK: begin
        res_d.status = hrsl_pkg::ST_OK;
        if (top_hit.hit) begin
          res_d.owner   = top_hit.owner;
          res_d.wrapped = 1'b0;
        end else begin
          res_d.owner   = cell_own[0];
          res_d.wrapped = 1'b1;
        end
      end
      hrsl_pkg::LU_DONE: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hrsl_pkg::LU_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_q.wrapped, out_q.owner};
  assign m_axis_tuser  = out_q.status;

  `HRSL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
  `HRSL_ASSERT_NEXT(a_full_drop,
    in_acc && in_kind == hrsl_pkg::KIND_INSERT && count_q == CW'(DEPTH),
    count_q == CW'(DEPTH))
  `HRSL_ASSERT_NEXT(a_clear_empty, in_acc && in_kind == hrsl_pkg::KIND_CLEAR, count_q == '0)
  `HRSL_ASSERT_NEXT(a_lookup_start,
    in_acc && in_kind == hrsl_pkg::KIND_LOOKUP && count_q != '0,
    state_q == hrsl_pkg::LU_CELL && $stable(count_q))

endmodule
